@@ rtl/mwo_pkg.sv @@
`timescale 1ns / 1ps
package mwo_pkg;

  localparam int PHASE_BITS_DEF     = 32;
  localparam int SINE_ADDR_BITS_DEF = 10;
  localparam int HARMONICS_DEF      = 49;
  localparam int SAMPLE_BITS_DEF    = 16;

  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED    = 1'd1;

  localparam logic [31:0] SILENCE_RESET = 32'd97392;
  localparam logic [31:0] SEED_RESET    = 32'd1;
  localparam logic [31:0] LFSR_MASK     = 32'h80200003;
  localparam logic [29:0] TWO_OVER_PI_Q30 = 30'd683565276;
  localparam logic [30:0] HALF_PI_Q30     = 31'd1686629713;

  localparam int MAX_HARM = 63;
  localparam int HARM_IDX_W = 6;

  typedef enum logic [2:0] {
    FN_SINE   = 3'd0,
    FN_SQUARE = 3'd1,
    FN_TRI    = 3'd2,
    FN_HSAW   = 3'd3,
    FN_RAMP   = 3'd4,
    FN_NOISE  = 3'd5,
    FN_ZERO6  = 3'd6,
    FN_ZERO7  = 3'd7
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOOK,
    ST_SIMPLE,
    ST_HARM,
    ST_HSUM,
    ST_ROUND,
    ST_NOISE,
    ST_OUT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture input item, bump counter
    logic mul;        // form phase
    logic harm_clr;   // clear harmonic accumulator
    logic harm_step;  // add one harmonic term
    logic harm_fin;   // round accumulated sum
    logic noise_step; // one lfsr step
    logic simple;     // compute direct waveform
  } dp_cmd_t;

  typedef struct packed {
    logic harm_last;
    logic noise_last;
    logic silent;
    func_t func;
  } dp_sts_t;

  // harmonic weight round(2^30*2/pi/n)
  function automatic logic [29:0] harm_weight(input logic [HARM_IDX_W-1:0] n);
    logic [30:0] t;
    begin
      if (n == '0) begin
        harm_weight = '0;
      end else begin
        t = ({1'b0, TWO_OVER_PI_Q30} + 31'(n >> 1)) / 31'(n);
        harm_weight = t[29:0];
      end
    end
  endfunction

  // quarter sine table entry, computed with a fixed point series
  function automatic logic [23:0] rom_value(input int k, input int abits, input int sbits);
    logic [63:0] x, x2, h, s, a, fs1;
    int divs [6];
    begin
      divs[0] = 156; divs[1] = 110; divs[2] = 72;
      divs[3] = 42; divs[4] = 20; divs[5] = 6;
      fs1 = (64'd1 << (sbits - 1)) - 64'd1;
      x = (64'(HALF_PI_Q30) * (64'(2 * k) + 64'd1)) >> (abits + 1);
      x2 = (x * x) >> 30;
      h = 64'd1 << 30;
      for (int i = 0; i < 6; i++) begin
        h = (64'd1 << 30) - (((x2 * h) >> 30) / 64'(divs[i]));
      end
      s = (x * h) >> 30;
      a = (s * fs1 + (64'd1 << 29)) >> 30;
      if (a > fs1) a = fs1;
      rom_value = a[23:0];
    end
  endfunction

endpackage

@@ rtl/mwo_if.sv @@
`timescale 1ns / 1ps
interface mwo_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] tuning;
  logic [2:0]  func;
  modport source (output valid, tuning, func, input ready);
  modport sink (input valid, tuning, func, output ready);
endinterface

interface mwo_out_if #(parameter int SAMPLE_BITS = mwo_pkg::SAMPLE_BITS_DEF);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface

@@ rtl/mwo_ctrl.sv @@
`timescale 1ns / 1ps
module mwo_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  mwo_pkg::dp_sts_t  sts,
  output mwo_pkg::dp_cmd_t  cmd
);

  mwo_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mwo_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mwo_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = mwo_pkg::ST_MUL;
      end
      mwo_pkg::ST_MUL: begin
        if (sts.silent) state_nxt = mwo_pkg::ST_LOOK;
        else if (sts.func == mwo_pkg::FN_HSAW) state_nxt = mwo_pkg::ST_HARM;
        else if (sts.func == mwo_pkg::FN_NOISE) state_nxt = mwo_pkg::ST_NOISE;
        else state_nxt = mwo_pkg::ST_LOOK;
      end
      // table read of the base phase
      mwo_pkg::ST_LOOK: state_nxt = mwo_pkg::ST_SIMPLE;
      mwo_pkg::ST_SIMPLE: state_nxt = mwo_pkg::ST_OUT;
      mwo_pkg::ST_HARM: begin
        if (sts.harm_last) state_nxt = mwo_pkg::ST_HSUM;
      end
      // last term enters the accumulator
      mwo_pkg::ST_HSUM: state_nxt = mwo_pkg::ST_ROUND;
      mwo_pkg::ST_ROUND: state_nxt = mwo_pkg::ST_OUT;
      mwo_pkg::ST_NOISE: begin
        if (sts.noise_last) state_nxt = mwo_pkg::ST_OUT;
      end
      mwo_pkg::ST_OUT: begin
        // accept the next item as soon as the result has been taken
        if (out_ready) state_nxt = mwo_pkg::ST_IDLE;
      end
      default: state_nxt = mwo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      mwo_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      mwo_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
        cmd.harm_clr = 1'b1;
      end
      mwo_pkg::ST_SIMPLE: cmd.simple = 1'b1;
      mwo_pkg::ST_HARM: cmd.harm_step = 1'b1;
      mwo_pkg::ST_ROUND: cmd.harm_fin = 1'b1;
      mwo_pkg::ST_NOISE: cmd.noise_step = 1'b1;
      mwo_pkg::ST_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

@@ rtl/mwo_dp.sv @@
`timescale 1ns / 1ps
module mwo_dp #(
  parameter int PHASE_BITS     = mwo_pkg::PHASE_BITS_DEF,
  parameter int SINE_ADDR_BITS = mwo_pkg::SINE_ADDR_BITS_DEF,
  parameter int HARMONICS      = mwo_pkg::HARMONICS_DEF,
  parameter int SAMPLE_BITS    = mwo_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [mwo_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mwo_pkg::CFG_W-1:0]          cfg_data,
  input  logic [31:0]                        tuning,
  input  logic [2:0]                         func,
  input  mwo_pkg::dp_cmd_t                   cmd,
  output mwo_pkg::dp_sts_t                   sts,
  output logic signed [SAMPLE_BITS-1:0]      sample
);

  localparam int ROM_SIZE = 1 << SINE_ADDR_BITS;
  localparam int SB = SAMPLE_BITS;
  localparam int NB_W = $clog2(SB + 1);
  localparam int ACC_W = SB + 30 + 7;
  localparam logic signed [SB:0] FS_P = (SB+1)'((1 << (SB - 1)) - 1);
  localparam logic signed [SB:0] FS_N = -(SB+1)'(1 << (SB - 1));

  logic [31:0]              thr_r, noise_r, noise_nxt;
  logic [31:0]              count_r;
  logic [31:0]              tuning_r;
  mwo_pkg::func_t           func_r;
  logic [PHASE_BITS-1:0]    phase_r, hph_r;
  logic [mwo_pkg::HARM_IDX_W-1:0] n_r;
  logic [NB_W-1:0]          nb_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [SB-1:0]     sample_r, sample_nxt;
  logic [63:0]              prod;
  logic [SB-1:0]            f;

  // quarter sine table, registered read: data in the cycle after the address
  logic [SB-2:0]             sine_rom [ROM_SIZE];
  logic [1:0]                quad, quad_r;
  logic [SINE_ADDR_BITS-1:0] idx;
  logic [SB-2:0]             rom_q_r;
  logic [29:0]               w, w_r;
  logic                      hv_r;
  logic signed [SB:0]        sine_v;
  logic signed [SB+30:0]     term;

  initial begin
    for (int k = 0; k < ROM_SIZE; k++) begin
      sine_rom[k] = (SB-1)'(mwo_pkg::rom_value(k, SINE_ADDR_BITS, SB));
    end
  end

  always_comb begin
    quad = hph_r[PHASE_BITS-1 -: 2];
    idx = hph_r[PHASE_BITS-3 -: SINE_ADDR_BITS];
    if (quad[0]) idx = ~idx;
  end

  // harmonic weight table
  always_comb begin
    w = '0;
    for (int k = 1; k <= mwo_pkg::MAX_HARM; k++) begin
      if (n_r == mwo_pkg::HARM_IDX_W'(k)) begin
        w = mwo_pkg::harm_weight(mwo_pkg::HARM_IDX_W'(k));
      end
    end
  end

  always_ff @(posedge clk) begin
    rom_q_r <= sine_rom[idx];
    quad_r <= quad;
    w_r <= w;
    hv_r <= cmd.harm_step;
  end

  assign sine_v = quad_r[1] ? -$signed({2'b00, rom_q_r}) : $signed({2'b00, rom_q_r});
  assign term = sine_v * $signed({1'b0, w_r});

  assign prod = count_r * tuning_r;
  assign f = SB'({phase_r, {SB{1'b0}}} >> PHASE_BITS);

  // rounding of the sum and saturation
  logic [ACC_W-1:0] mag, rnd;
  logic signed [ACC_W:0] rs;
  always_comb begin
    mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    rnd = (mag + (ACC_W'(1) << 29)) >> 30;
    rs = acc_r[ACC_W-1] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
  end

  // direct waveforms
  logic signed [SB+1:0] tri_v;
  logic [SB-3:0] r;
  logic signed [SB-1:0] sine_s;
  always_comb begin
    r = f[SB-3:0];
    tri_v = '0;
    case (f[SB-1 -: 2])
      2'd0: tri_v = $signed({3'b000, r, 1'b0});
      2'd1: tri_v = (SB+2)'(FS_P) + (SB+2)'(1) - $signed({3'b000, r, 1'b0});
      2'd2: tri_v = -$signed({3'b000, r, 1'b0});
      default: tri_v = (SB+2)'(FS_N) + $signed({3'b000, r, 1'b0});
    endcase
    if (tri_v > (SB+2)'(FS_P)) tri_v = (SB+2)'(FS_P);
  end

  // sine output from the table read of the base phase
  assign sine_s = quad_r[1] ? -$signed({1'b0, rom_q_r}) : $signed({1'b0, rom_q_r});

  logic [31:0] lfsr_step;
  assign lfsr_step = noise_r[0] ? ((noise_r >> 1) ^ mwo_pkg::LFSR_MASK) : (noise_r >> 1);

  always_comb begin
    sample_nxt = sample_r;
    noise_nxt = noise_r;
    if (cmd.simple) begin
      if (sts.silent) begin
        sample_nxt = '0;
      end else begin
        case (func_r)
          mwo_pkg::FN_SINE: sample_nxt = sine_s;
          mwo_pkg::FN_SQUARE: sample_nxt = (phase_r != '0 && !phase_r[PHASE_BITS-1])
                                           ? SB'(FS_P) : SB'(FS_N);
          mwo_pkg::FN_TRI: sample_nxt = SB'(tri_v);
          mwo_pkg::FN_RAMP: sample_nxt = $signed({~f[SB-1], f[SB-2:0]});
          default: sample_nxt = '0;
        endcase
      end
    end
    if (cmd.harm_fin) begin
      if (rs > (ACC_W+1)'(FS_P)) sample_nxt = SB'(FS_P);
      else if (rs < (ACC_W+1)'(FS_N)) sample_nxt = SB'(FS_N);
      else sample_nxt = SB'(rs);
    end
    if (cmd.noise_step) begin
      noise_nxt = lfsr_step;
      if (nb_r == NB_W'(SB - 1)) sample_nxt = $signed(lfsr_step[31 -: SB]);
    end
    if (cfg_we && cfg_index == mwo_pkg::REG_SEED) begin
      noise_nxt = (cfg_data == '0) ? 32'd1 : cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= mwo_pkg::SILENCE_RESET;
      noise_r <= mwo_pkg::SEED_RESET;
      count_r <= '0;
    end else begin
      if (cfg_we && cfg_index == mwo_pkg::REG_SILENCE) thr_r <= cfg_data;
      noise_r <= noise_nxt;
      if (cmd.load) count_r <= count_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tuning_r <= tuning;
      func_r <= mwo_pkg::func_t'(func);
    end
    if (cmd.load) phase_r <= '0;
    if (cmd.mul) begin
      phase_r <= PHASE_BITS'(prod);
      hph_r <= PHASE_BITS'(prod);
      n_r <= mwo_pkg::HARM_IDX_W'(1);
      nb_r <= '0;
    end
    if (cmd.harm_clr) acc_r <= '0;
    // term of the previous step arrives from the registered table read in the next cycle
    if (hv_r) acc_r <= acc_r + ACC_W'(term);
    if (cmd.harm_step) begin
      hph_r <= hph_r + phase_r;
      n_r <= n_r + 1'b1;
    end
    if (cmd.noise_step) nb_r <= nb_r + 1'b1;
    sample_r <= sample_nxt;
  end

  assign sts.silent = tuning_r < thr_r;
  assign sts.func = func_r;
  assign sts.harm_last = (n_r == mwo_pkg::HARM_IDX_W'(HARMONICS));
  assign sts.noise_last = (nb_r == NB_W'(SB - 1));
  assign sample = sample_r;

endmodule

@@ rtl/multi_waveform_oscillator_unit.sv @@
`timescale 1ns / 1ps
// multi-waveform dds oscillator
// in channel: one transfer per sample tick, carrying tuning word and waveform code
// out channel: one transfer per input, the signed sample
// cfg port: index 0 silence threshold, index 1 noise seed (also reloads noise at once)
// each tick bumps the sample counter, phase = count * tuning, then the waveform is formed
// sine, square, triangle, ramp, zero and silence pass through phase multiply,
// registered sine table read and waveform select before out valid
// harmonic saw forms one harmonic term per cycle through the
// registered sine table and a (SAMPLE_BITS+1) x 31 multiplier into the accumulator
// noise: one lfsr shift per cycle
// one item at a time: next input is taken the cycle after the result transfers
// a stalled receiver holds the result; the input side waits with ready low
// reset: counter cleared, threshold 97392, noise register 1
// no clearing pass: sine table contents are fixed at build, weights are constant logic
module multi_waveform_oscillator_unit #(
  parameter int PHASE_BITS     = mwo_pkg::PHASE_BITS_DEF,
  parameter int SINE_ADDR_BITS = mwo_pkg::SINE_ADDR_BITS_DEF,
  parameter int HARMONICS      = mwo_pkg::HARMONICS_DEF,
  parameter int SAMPLE_BITS    = mwo_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mwo_in_if.sink                        in_ch,
  mwo_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [mwo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mwo_pkg::CFG_W-1:0]     cfg_data
);

  mwo_pkg::dp_cmd_t cmd;
  mwo_pkg::dp_sts_t sts;

  // sequencer: load, multiply, then per-waveform iteration, then hold result
  mwo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: counter, phase product, waveform units, accumulator, lfsr
  mwo_dp #(
    .PHASE_BITS     (PHASE_BITS),
    .SINE_ADDR_BITS (SINE_ADDR_BITS),
    .HARMONICS      (HARMONICS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tuning    (in_ch.tuning),
    .func      (in_ch.func),
    .cmd       (cmd),
    .sts       (sts),
    .sample    (out_ch.sample)
  );

endmodule

@@ rtl/mwo_checker.sv @@
`timescale 1ns / 1ps
module mwo_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // never both sides open at once in this sequential design
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("ready while result pending");

  // accepted input never yields an output in the next cycle
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result too early");

  // after an output transfer the block returns to accepting
  a_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> in_ready)
    else $error("not ready after transfer");

  // result stays offered while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped");

endmodule

bind multi_waveform_oscillator_unit mwo_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);
